// ===== rtl/lpfs_pkg.sv =====
// Shared types and constants of the length-prefixed frame splitter.
package lpfs_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned VER_W  = 4;
   localparam int unsigned LEN_W  = 32;
   localparam int unsigned POS_W  = 33;
   localparam int unsigned HDR_W  = 7;

   // Header sizes and version codes
   localparam int unsigned HEADER_ONE_BYTES = 8;
   localparam int unsigned HEADER_TWO_BYTES = 12;
   localparam int unsigned VERSION_ONE_CODE = 1;
   localparam int unsigned VERSION_TWO_CODE = 2;

   // Smallest legal header; a frame of this size with zero length ends at byte 7
   localparam int unsigned HDR_MIN_BYTES = 8;

   // Header byte positions of the big-endian length field
   localparam int unsigned POS_LEN_B3 = 4;
   localparam int unsigned POS_LEN_B2 = 5;
   localparam int unsigned POS_LEN_B1 = 6;
   localparam int unsigned POS_LEN_B0 = 7;

   // One classified item as it travels from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_first;
      logic              frame_last;
      logic [VER_W-1:0]  frame_version;
      logic              bad_version;
   } lpfs_item_type;

endpackage

// ===== rtl/length_prefixed_frame_splitter_core.sv =====
// Top level of the length-prefixed frame splitter: front end, queue and back end.
//
// Usage
//  - req channel: one stream byte per item on req_in_byte, valid/ready handshake.
//  - rsp channel: one result item per forwarded byte, with first/last marks,
//    the frame's version nibble, and bad_version on the single error item.
//  - A byte is taken at every cycle the queue has room, so a steady stream
//    runs at one item per cycle in and out while rsp_ready stays high.
//  - Path: an accepted byte is written into the queue, then loaded into the
//    output register, which drives rsp_valid and holds it until the rsp handshake.
//  - The front end compares the frame position counter against the stored last
//    index; the last index is formed by a 33-bit add and subtract when length byte 7 lands.
//  - An unsupported version gives one error item at the last version-one header
//    byte; afterwards every byte is accepted and dropped until reset.
//  - Receiver stall: the output register holds its item, the queue fills
//    (QUEUE_DEPTH items), then req_ready falls until room frees up, unless stuck.
//  - Reset (synchronous, active high) clears position, version, the length-known flag,
//    the sticky error, the queue pointers and count and the output valid flag; no clearing pass.
module length_prefixed_frame_splitter_core
   import lpfs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_frame_first,
   output logic              rsp_frame_last,
   output logic [VER_W-1:0]  rsp_frame_version,
   output logic              rsp_bad_version
);

   // front to queue
   logic          q_push;
   lpfs_item_type q_push_item;
   logic          q_full;

   // queue to back
   logic          q_pop;
   logic          q_not_empty;
   lpfs_item_type q_head_item;

   lpfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   lpfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (q_head_item)
   );

   lpfs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_item            (q_head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_first   (rsp_frame_first),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_frame_version (rsp_frame_version),
      .rsp_bad_version   (rsp_bad_version)
   );

endmodule

// ===== rtl/lpfs_front.sv =====
// Front end: accepts stream bytes, tracks frame position and classifies each byte.
module lpfs_front
   import lpfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              q_full,
   output logic              q_push,
   output lpfs_item_type     q_item
);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [VER_W-1:0]     ver_ff, ver_in;
   logic [LEN_W-9:0]     len_ff, len_in;       // upper three length bytes
   logic [POS_W-1:0]     last_idx_ff, last_idx_in;
   logic                 known_ff, known_in;
   logic                 stuck_ff, stuck_in;

   logic [VER_W-1:0]     ver_now;
   logic                 is_one;
   logic                 is_two;
   logic                 bad;
   logic [HDR_W-1:0]     hdr_bytes;
   logic [LEN_W-1:0]     len_full;
   logic                 at_first;
   logic                 at_len_end;
   logic                 last_now;
   logic                 err_now;
   logic                 accept;

   assign at_first   = (pos_ff == '0);
   assign at_len_end = (pos_ff == POS_W'(POS_LEN_B0));
   assign ver_now    = at_first ? req_in_byte[BYTE_W-1 -: VER_W] : ver_ff;
   assign is_one     = (ver_now == VER_W'(VERSION_ONE_CODE));
   assign is_two     = (ver_now == VER_W'(VERSION_TWO_CODE));
   assign bad        = !is_one && !is_two;
   // version one wins when both codes match
   assign hdr_bytes  = is_one ? HDR_W'(HEADER_ONE_BYTES) : HDR_W'(HEADER_TWO_BYTES);
   assign len_full   = {len_ff, req_in_byte};

   // last index of the frame, only needed when the length completes
   assign last_idx_in = at_len_end ?
                        (POS_W'(len_full) + POS_W'(hdr_bytes) - POS_W'(1)) : last_idx_ff;

   always_comb begin
      if (bad) begin
         last_now = 1'b0;
      end else if (at_len_end) begin
         // header-only frame of minimum size ends on the last length byte
         last_now = (hdr_bytes == HDR_W'(HDR_MIN_BYTES)) && (len_full == '0);
      end else begin
         last_now = known_ff && (pos_ff == last_idx_ff);
      end
   end

   assign err_now   = bad && (pos_ff == POS_W'(HEADER_ONE_BYTES - 1));

   // once stuck every byte is swallowed without a result
   assign req_ready = stuck_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && !stuck_ff;

   assign q_item.out_byte      = req_in_byte;
   assign q_item.frame_first   = at_first && !err_now;
   assign q_item.frame_last    = last_now && !err_now;
   assign q_item.frame_version = ver_now;
   assign q_item.bad_version   = err_now;

   always_comb begin
      pos_in   = pos_ff;
      ver_in   = ver_ff;
      len_in   = len_ff;
      known_in = known_ff;
      stuck_in = stuck_ff;
      if (q_push) begin
         if (at_first) begin
            ver_in = req_in_byte[BYTE_W-1 -: VER_W];
         end
         if (pos_ff == POS_W'(POS_LEN_B3)) begin
            len_in[23:16] = req_in_byte;
         end
         if (pos_ff == POS_W'(POS_LEN_B2)) begin
            len_in[15:8] = req_in_byte;
         end
         if (pos_ff == POS_W'(POS_LEN_B1)) begin
            len_in[7:0] = req_in_byte;
         end
         if (at_len_end) begin
            known_in = 1'b1;
         end
         if (err_now) begin
            stuck_in = 1'b1;
         end else if (last_now) begin
            pos_in   = '0;
            known_in = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ver_ff   <= '0;
         known_ff <= 1'b0;
         stuck_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         ver_ff   <= ver_in;
         known_ff <= known_in;
         stuck_ff <= stuck_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (q_push) begin
         last_idx_ff <= last_idx_in;
      end
   end

endmodule

// ===== rtl/lpfs_queue.sv =====
// Short register queue between the front and back ends.
module lpfs_queue
   import lpfs_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lpfs_item_type push_item,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output lpfs_item_type head_item
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   lpfs_item_type  slot_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/lpfs_back.sv =====
// Back end: drains the queue into the registered result channel.
module lpfs_back
   import lpfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  lpfs_item_type     q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_frame_first,
   output logic              rsp_frame_last,
   output logic [VER_W-1:0]  rsp_frame_version,
   output logic              rsp_bad_version
);

   logic          valid_ff, valid_in;
   lpfs_item_type item_ff;
   logic          load;

   // refill the output register when it is empty or being taken
   assign load  = q_not_empty && (!valid_ff || rsp_ready);
   assign q_pop = load;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= q_item;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = item_ff.out_byte;
   assign rsp_frame_first   = item_ff.frame_first;
   assign rsp_frame_last    = item_ff.frame_last;
   assign rsp_frame_version = item_ff.frame_version;
   assign rsp_bad_version   = item_ff.bad_version;

endmodule

// ===== verif/length_prefixed_frame_splitter_core_tb.sv =====
// Self-checking bench for the frame splitter: table-driven frames, random frames, error tail.
module length_prefixed_frame_splitter_core_tb;
   import lpfs_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
   localparam int unsigned RANDOM_BYTES = 1750;
   localparam int unsigned LONG_HOLD    = 120;   // one long receiver stall to back the core up

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_frame_first;
   logic              rsp_frame_last;
   logic [VER_W-1:0]  rsp_frame_version;
   logic              rsp_bad_version;

   length_prefixed_frame_splitter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_frame_first   (rsp_frame_first),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_frame_version (rsp_frame_version),
      .rsp_bad_version   (rsp_bad_version)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Frame tracker: mirrors the splitter's view of the stream, one byte at a time.
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] trk_pos       = '0;  // index of the next byte in its frame
   logic [VER_W-1:0] trk_ver       = '0;
   logic [LEN_W-1:0] trk_len       = '0;
   logic [POS_W-1:0] trk_total     = '0;  // header plus payload, known from byte 7
   bit               trk_len_known = 1'b0;
   bit               trk_stuck     = 1'b0;  // sticky after a bad version

   lpfs_item_type pending_items[$];       // results owed by the core, oldest first

   function automatic lpfs_item_type make_item(input logic [BYTE_W-1:0] b, input bit first,
                                               input bit last, input logic [VER_W-1:0] ver,
                                               input bit bad);
      lpfs_item_type it;
      it.out_byte      = b;
      it.frame_first   = first;
      it.frame_last    = last;
      it.frame_version = ver;
      it.bad_version   = bad;
      return it;
   endfunction

   task automatic track_frame_byte(input logic [BYTE_W-1:0] b, output bit produced,
                                   output lpfs_item_type res);
      logic [POS_W-1:0] p;
      int unsigned      hdr;
      bit               bad;
      bit               last;
      produced = 1'b0;
      res      = '0;
      if (!trk_stuck) begin
         p = trk_pos;
         if (p == 0) begin
            trk_ver = b[7:4];
            trk_len = '0;
         end
         case (p)
            POS_LEN_B3: trk_len[31:24] = b;
            POS_LEN_B2: trk_len[23:16] = b;
            POS_LEN_B1: trk_len[15:8]  = b;
            POS_LEN_B0: trk_len[7:0]   = b;
            default: ;
         endcase
         // version one is checked first, so it wins if both codes match
         if (trk_ver == VER_W'(VERSION_ONE_CODE))      hdr = HEADER_ONE_BYTES;
         else if (trk_ver == VER_W'(VERSION_TWO_CODE)) hdr = HEADER_TWO_BYTES;
         else                                          hdr = 0;
         bad = (hdr == 0);
         if (p == POS_LEN_B0) begin
            trk_len_known = 1'b1;
            trk_total     = bad ? '0 : POS_W'(hdr) + POS_W'(trk_len);
         end
         produced = 1'b1;
         if (bad && p == POS_W'(HEADER_ONE_BYTES - 1)) begin
            // unsupported version: single error item, then everything is dropped
            res       = make_item(b, 1'b0, 1'b0, trk_ver, 1'b1);
            trk_stuck = 1'b1;
         end else begin
            last = !bad && trk_len_known && trk_total != 0 && p == trk_total - 1;
            res  = make_item(b, p == 0, last, trk_ver, 1'b0);
            if (last) begin
               trk_pos       = '0;
               trk_len_known = 1'b0;
            end else begin
               trk_pos = p + 1;
            end
         end
      end
   endtask

   // Mostly back-to-back, some short gaps, the odd long one.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: one byte per item, valid held with the byte until accepted.
   // ---------------------------------------------------------------------------
   bit tx_burst = 1'b0;  // no gaps while set

   task automatic offer_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input lpfs_item_type want = '0);
      int unsigned   g;
      bit            got;
      lpfs_item_type res;
      g = tx_burst ? 0 : gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      track_frame_byte(b, got, res);
      if (typed)
         pending_items.insert(pending_items.size(), want);
      else if (got)
         pending_items.insert(pending_items.size(), res);
   endtask

   // Well-formed frame of a supported version with random content.
   task automatic send_random_frame(output int unsigned nbytes);
      logic [VER_W-1:0] ver;
      logic [BYTE_W-1:0] b0;
      logic [LEN_W-1:0] len;
      logic [BYTE_W-1:0] b;
      int unsigned      hdr;
      ver = $urandom_range(0, 1) ? VER_W'(VERSION_TWO_CODE) : VER_W'(VERSION_ONE_CODE);
      hdr = (ver == VER_W'(VERSION_ONE_CODE)) ? HEADER_ONE_BYTES : HEADER_TWO_BYTES;
      b0  = {ver, 4'($urandom_range(0, 15))};
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 300);
      tx_burst = ($urandom_range(0, 3) == 0);
      nbytes   = hdr + len;
      for (int unsigned i = 0; i < nbytes; i++) begin
         case (i)
            0:          b = b0;
            POS_LEN_B3: b = len[31:24];
            POS_LEN_B2: b = len[23:16];
            POS_LEN_B1: b = len[15:8];
            POS_LEN_B0: b = len[7:0];
            default:    b = BYTE_W'($urandom);
         endcase
         offer_byte(b);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Directed table: typed expectations only where they are obvious.
   // ---------------------------------------------------------------------------
   typedef struct {
      logic [BYTE_W-1:0] b;
      bit                typed;
      lpfs_item_type     want;
   } stim_row_type;

   stim_row_type frame_rows[$];
   stim_row_type error_rows[$];

   task automatic add_row(inout stim_row_type rows[$], input logic [BYTE_W-1:0] b,
                          input bit typed = 1'b0, input lpfs_item_type want = '0);
      stim_row_type r;
      r.b     = b;
      r.typed = typed;
      r.want  = want;
      rows.insert(rows.size(), r);
   endtask

   task automatic build_tables();
      // version one, zero length: header-only frame, last mark on byte 7
      add_row(frame_rows, 8'h10, 1'b1, make_item(8'h10, 1'b1, 1'b0, 4'h1, 1'b0));
      for (int i = 1; i < 7; i++) add_row(frame_rows, 8'h00);
      add_row(frame_rows, 8'h00, 1'b1, make_item(8'h00, 1'b0, 1'b1, 4'h1, 1'b0));
      // version two, length one: filler bytes in the header, one payload byte
      add_row(frame_rows, 8'h2F, 1'b1, make_item(8'h2F, 1'b1, 1'b0, 4'h2, 1'b0));
      add_row(frame_rows, 8'hFF);
      add_row(frame_rows, 8'hFF);
      add_row(frame_rows, 8'hFF);
      add_row(frame_rows, 8'h00);
      add_row(frame_rows, 8'h00);
      add_row(frame_rows, 8'h00);
      add_row(frame_rows, 8'h01);
      add_row(frame_rows, 8'hA5);
      add_row(frame_rows, 8'h5A);
      add_row(frame_rows, 8'hFF);
      add_row(frame_rows, 8'h00);
      add_row(frame_rows, 8'h80, 1'b1, make_item(8'h80, 1'b0, 1'b1, 4'h2, 1'b0));

      // bad version: length bytes ignored, error item at the last v1 header byte,
      // then the core is stuck and drops what follows
      add_row(error_rows, 8'hFF, 1'b1, make_item(8'hFF, 1'b1, 1'b0, 4'hF, 1'b0));
      for (int i = 1; i < 7; i++) add_row(error_rows, (i == 4) ? 8'h7F : 8'h00);
      add_row(error_rows, 8'hC3, 1'b1, make_item(8'hC3, 1'b0, 1'b0, 4'hF, 1'b1));
      add_row(error_rows, 8'h12);
      add_row(error_rows, 8'h34);
      add_row(error_rows, 8'hFF);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, calm stretches, and one long hold-off.
   // ---------------------------------------------------------------------------
   int unsigned results_seen = 0;
   int unsigned rx_stall     = 0;
   int unsigned rx_calm      = 0;
   bit          rx_long_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_stall != 0) begin
         rsp_ready <= 1'b0;
         rx_stall  <= rx_stall - 1;
      end else if (!rx_long_done && results_seen >= 300) begin
         // sender keeps going; queue fills and req_ready must drop
         rx_long_done <= 1'b1;
         rx_stall     <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (rx_calm != 0) begin
         rsp_ready <= 1'b1;
         rx_calm   <= rx_calm - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            rx_stall <= gap_len();
         else if ($urandom_range(0, 19) == 0)
            rx_calm <= 60;
      end
   end

   // ---------------------------------------------------------------------------
   // Result check against the oldest owed item.
   // ---------------------------------------------------------------------------
   int unsigned mismatches = 0;

   always @(posedge clock) begin
      lpfs_item_type got;
      lpfs_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = make_item(rsp_out_byte, rsp_frame_first, rsp_frame_last, rsp_frame_version,
                         rsp_bad_version);
         results_seen <= results_seen + 1;
         if (pending_items.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected result byte %h first %b last %b ver %h bad %b",
                        $time, got.out_byte, got.frame_first, got.frame_last,
                        got.frame_version, got.bad_version);
            mismatches <= mismatches + 1;
         end else begin
            want = pending_items.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("%0t: mismatch want byte %h first %b last %b ver %h bad %b",
                           $time, want.out_byte, want.frame_first, want.frame_last,
                           want.frame_version, want.bad_version);
                  $display("%0t:           got byte %h first %b last %b ver %h bad %b",
                           $time, got.out_byte, got.frame_first, got.frame_last,
                           got.frame_version, got.bad_version);
               end
               mismatches <= mismatches + 1;
            end
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned sent;
      int unsigned n;
      sent = 0;
      build_tables();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (frame_rows[i])
         offer_byte(frame_rows[i].b, frame_rows[i].typed, frame_rows[i].want);

      while (sent < RANDOM_BYTES) begin
         send_random_frame(n);
         sent += n;
      end

      // sticky error last: nothing after it can produce a result
      tx_burst = 1'b0;
      foreach (error_rows[i])
         offer_byte(error_rows[i].b, error_rows[i].typed, error_rows[i].want);
      req_valid <= 1'b0;

      while (pending_items.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && pending_items.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
